>>> design/lsrd_pkg.sv
// ----------------------------------------------------------------------------
// lsrd_pkg: shared constants for the laser scan reply decoder
// Field widths, framing constants, register indexes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsrd_pkg;

  // Field widths
  localparam int STEP_W   = 10;
  localparam int GROUP_W  = 2;
  localparam int DIST_W   = 12;
  localparam int DIGIT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Framing
  localparam int SYNC_LIMIT      = 2000;
  localparam int BYTE_CNT_W      = 11;
  localparam int POINTS_PER_LINE = 32;
  localparam int LINE_CNT_W      = $clog2(POINTS_PER_LINE + 1);
  localparam int HEADER_BYTES    = 11;
  localparam logic [7:0] CHAR_BIAS = 8'h30;
  localparam logic [7:0] SYNC_BYTE = 8'h47;   // 'G'

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(STEP_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 3'd4;

  // Result status codes
  localparam logic ST_POINT   = 1'b0;
  localparam logic ST_TIMEOUT = 1'b1;

endpackage

`default_nettype wire

>>> design/laser_scan_reply_decoder.sv
// A result item is presented in the cycle after the byte that completes it.
// Input: one byte per cycle while results drain and no division runs; a 'G'
//   byte stalls the input while the shift-subtract unit forms the point
//   count (last - first) / group one quotient bit per cycle.
// Reset (rst, synchronous): hunting for 'G', counters cleared, registers at defaults.
// ----------------------------------------------------------------------------
// laser_scan_reply_decoder: range scan reply decoder
// Hunts for the reply sync byte (reporting timeouts), skips the header, then decodes
// two-character six-bit distances into points with angle, index and last-point flag.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_reply_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     rx_byte,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                status,
  output logic [lsrd_pkg::DIST_W-1:0]         distance,
  output logic signed [lsrd_pkg::STEP_W-1:0]  point_angle,
  output logic [lsrd_pkg::STEP_W-1:0]         point_number,
  output logic                                last_point,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lsrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lsrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsrd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } seq_t;

  // Configuration registers
  logic [STEP_W-1:0]  first_step;
  logic [STEP_W-1:0]  last_step;
  logic [GROUP_W-1:0] group_size;
  logic [STEP_W-1:0]  angle_origin;
  logic [DIST_W-1:0]  min_valid_range;

  // Decoder state
  seq_t                  seq;
  phase_t                phase;
  logic [BYTE_CNT_W-1:0] byte_count;
  logic [STEP_W-1:0]     points_total;
  logic [STEP_W-1:0]     point_count;
  logic [LINE_CNT_W-1:0] group_count;
  logic [DIGIT_W-1:0]    high_digit;
  logic                  second_char_pending;
  logic [STEP_W-1:0]     angle_now;

  // Divider state
  logic [STEP_W-1:0]    div_q;
  logic [GROUP_W-1:0]   div_rem;
  logic [GROUP_W-1:0]   div_g;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                  in_fire;
  logic                  res_load;
  logic [GROUP_W-1:0]    eff_group;
  logic [7:0]            char_diff;
  logic [DIGIT_W-1:0]    digit;
  logic [DIST_W-1:0]     dist_raw;
  logic [DIST_W-1:0]     dist_out;
  logic [BYTE_CNT_W:0]   byte_inc;
  logic [STEP_W:0]       point_inc;
  logic                  last_hit;
  logic [GROUP_W:0]      rem_sh;
  logic                  rem_ge;

  assign cfg_ready = 1'b1;
  assign in_stall  = (seq != S_IDLE) || (out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;

  // Byte decode helpers
  assign eff_group = (group_size == '0) ? GROUP_W'(1) : group_size;
  assign char_diff = rx_byte - CHAR_BIAS;
  assign digit     = char_diff[DIGIT_W-1:0];
  assign dist_raw  = {high_digit, digit};
  assign dist_out  = (dist_raw < min_valid_range) ? '0 : dist_raw;
  assign byte_inc  = {1'b0, byte_count} + 1'b1;
  assign point_inc = {1'b0, point_count} + 1'b1;
  assign last_hit  = point_inc >= {1'b0, points_total};

  // accepted byte yields a point or a sync timeout item
  assign res_load = in_fire &&
                    ((phase == PH_DATA) ? second_char_pending :
                     (phase != PH_HEADER) && (rx_byte != SYNC_BYTE) &&
                     (byte_inc >= (BYTE_CNT_W+1)'(SYNC_LIMIT)));

  // Shift-subtract step of the divider
  assign rem_sh = {div_rem, div_q[STEP_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_g};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_step      <= STEP_W'(44);
      last_step       <= STEP_W'(725);
      group_size      <= GROUP_W'(3);
      angle_origin    <= STEP_W'(341);
      min_valid_range <= DIST_W'(20);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_STEP:   first_step      <= cfg_data[STEP_W-1:0];
        REG_LAST_STEP:    last_step       <= cfg_data[STEP_W-1:0];
        REG_GROUP_SIZE:   group_size      <= cfg_data[GROUP_W-1:0];
        REG_ANGLE_ORIGIN: angle_origin    <= cfg_data[STEP_W-1:0];
        REG_MIN_RANGE:    min_valid_range <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, decoder state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq                 <= S_IDLE;
      phase               <= PH_HUNT;
      byte_count          <= '0;
      points_total        <= '0;
      point_count         <= '0;
      group_count         <= '0;
      second_char_pending <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      // new item loaded, or the held one taken downstream
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (seq)
        S_IDLE: begin
          if (in_fire) begin
            unique case (phase)
              PH_HEADER: begin
                if (byte_inc >= (BYTE_CNT_W+1)'(HEADER_BYTES)) begin
                  byte_count <= '0;
                  phase      <= (points_total == '0) ? PH_HUNT : PH_DATA;
                end else begin
                  byte_count <= byte_inc[BYTE_CNT_W-1:0];
                end
              end

              PH_DATA: begin
                if (!second_char_pending) begin
                  // line feed between full lines of points
                  if (group_count >= LINE_CNT_W'(POINTS_PER_LINE)) begin
                    group_count <= '0;
                  end else begin
                    high_digit          <= digit;
                    second_char_pending <= 1'b1;
                  end
                end else begin
                  second_char_pending <= 1'b0;
                  status       <= ST_POINT;
                  distance     <= dist_out;
                  point_angle  <= angle_now;
                  point_number <= point_count;
                  last_point   <= last_hit;
                  angle_now    <= angle_now - STEP_W'(eff_group);
                  point_count  <= point_inc[STEP_W-1:0];
                  group_count  <= group_count + 1'b1;
                  if (last_hit) begin
                    phase      <= PH_HUNT;
                    byte_count <= '0;
                  end
                end
              end

              default: begin
                // hunting for the sync byte
                if (rx_byte == SYNC_BYTE) begin
                  phase               <= PH_HEADER;
                  byte_count          <= '0;
                  point_count         <= '0;
                  group_count         <= '0;
                  high_digit          <= '0;
                  second_char_pending <= 1'b0;
                  angle_now           <= angle_origin;
                  // launch the point count division
                  div_q   <= (last_step > first_step) ? (last_step - first_step) : '0;
                  div_rem <= '0;
                  div_g   <= eff_group;
                  div_cnt <= DIV_CNT_W'(STEP_W - 1);
                  seq     <= S_DIV;
                end else if (byte_inc >= (BYTE_CNT_W+1)'(SYNC_LIMIT)) begin
                  phase        <= PH_HUNT;
                  byte_count   <= '0;
                  status       <= ST_TIMEOUT;
                  distance     <= '0;
                  point_angle  <= '0;
                  point_number <= '0;
                  last_point   <= 1'b0;
                end else begin
                  phase      <= PH_HUNT;
                  byte_count <= byte_inc[BYTE_CNT_W-1:0];
                end
              end
            endcase
          end
        end

        S_DIV: begin
          // one quotient bit per cycle
          div_rem <= rem_ge ? GROUP_W'(rem_sh - {1'b0, div_g}) : rem_sh[GROUP_W-1:0];
          div_q   <= {div_q[STEP_W-2:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            points_total <= {div_q[STEP_W-2:0], rem_ge};
            seq          <= S_IDLE;
          end
        end

        default: seq <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_laser_scan_reply_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laser_scan_reply_decoder: self-checking bench for the scan reply decoder
// Feeds serial bytes (reset-default scan, directed corner frames, sync
// timeouts, then randomized frames under several register settings) through a
// valid/stall driver. A byte-level decoder model in the bench predicts every
// point and timeout item. The monitor checks each item against the oldest
// prediction while both sides idle at random.
// ----------------------------------------------------------------------------

module tb_laser_scan_reply_decoder;
  import lsrd_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BYTES  = 1450;
  localparam logic [7:0] LINE_FEED = 8'h0A;

  typedef enum logic [1:0] {SCAN_HUNT, SCAN_HEADER, SCAN_DATA} scan_phase_t;

  typedef struct {
    logic                     status;
    logic [DIST_W-1:0]        distance;
    logic signed [STEP_W-1:0] angle;
    logic [STEP_W-1:0]        number;
    logic                     is_last;
  } scan_result_t;

  // DUT signals
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  logic [DIST_W-1:0] distance;
  logic signed [STEP_W-1:0] point_angle;
  logic [STEP_W-1:0] point_number;
  logic last_point;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_STEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register mirror
  logic [STEP_W-1:0]  cfg_first;
  logic [STEP_W-1:0]  cfg_last;
  logic [GROUP_W-1:0] cfg_group;
  logic [STEP_W-1:0]  cfg_origin;
  logic [DIST_W-1:0]  cfg_min_range;

  // Decoder model state
  scan_phase_t        scan_phase;
  int                 hunt_count;
  int                 points_total;
  int                 point_idx;
  int                 line_points;
  logic [DIGIT_W-1:0] high_digit;
  logic               low_pending;
  logic [STEP_W-1:0]  angle_now;

  scan_result_t predicted_points[$];
  logic [7:0]   byte_q[$];
  int pushed_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int calm_left = 0;
  scan_result_t due_point;

  laser_scan_reply_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .distance     (distance),
    .point_angle  (point_angle),
    .point_number (point_number),
    .last_point   (last_point),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void reset_model();
    cfg_first     = 10'd44;
    cfg_last      = 10'd725;
    cfg_group     = 2'd3;
    cfg_origin    = 10'd341;
    cfg_min_range = 12'd20;
    scan_phase    = SCAN_HUNT;
    hunt_count    = 0;
    points_total  = 0;
    point_idx     = 0;
    line_points   = 0;
    high_digit    = '0;
    low_pending   = 1'b0;
    angle_now     = '0;
  endfunction

  // group size zero steps like one
  function automatic int group_step();
    return (cfg_group == 0) ? 1 : int'(cfg_group);
  endfunction

  function automatic int scan_length();
    if (cfg_last > cfg_first)
      return (int'(cfg_last) - int'(cfg_first)) / group_step();
    return 0;
  endfunction

  // Advance the decoder by one accepted byte; queue any item it yields
  function automatic void decode_byte(input logic [7:0] rx);
    logic [7:0]        biased;
    logic [DIST_W-1:0] range_v;
    scan_result_t      res;
    biased = rx - CHAR_BIAS;
    case (scan_phase)
      SCAN_HEADER: begin
        hunt_count++;
        if (hunt_count >= HEADER_BYTES) begin
          hunt_count = 0;
          scan_phase = (points_total == 0) ? SCAN_HUNT : SCAN_DATA;
        end
      end
      SCAN_DATA: begin
        if (!low_pending) begin
          // a line feed separates full lines of points
          if (line_points >= POINTS_PER_LINE) begin
            line_points = 0;
          end else begin
            high_digit  = biased[DIGIT_W-1:0];
            low_pending = 1'b1;
          end
        end else begin
          low_pending = 1'b0;
          range_v = {high_digit, biased[DIGIT_W-1:0]};
          if (range_v < cfg_min_range) range_v = '0;
          res.status   = ST_POINT;
          res.distance = range_v;
          res.angle    = angle_now;
          res.number   = point_idx[STEP_W-1:0];
          res.is_last  = (point_idx + 1 >= points_total);
          predicted_points.push_back(res);
          angle_now = angle_now - STEP_W'(group_step());
          point_idx++;
          line_points++;
          if (point_idx >= points_total) begin
            scan_phase = SCAN_HUNT;
            hunt_count = 0;
          end
        end
      end
      default: begin
        scan_phase = SCAN_HUNT;
        hunt_count++;
        if (rx == SYNC_BYTE) begin
          scan_phase   = SCAN_HEADER;
          hunt_count   = 0;
          points_total = scan_length();
          point_idx    = 0;
          line_points  = 0;
          high_digit   = '0;
          low_pending  = 1'b0;
          angle_now    = cfg_origin;
        end else if (hunt_count >= SYNC_LIMIT) begin
          hunt_count   = 0;
          res.status   = ST_TIMEOUT;
          res.distance = '0;
          res.angle    = '0;
          res.number   = '0;
          res.is_last  = 1'b0;
          predicted_points.push_back(res);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- traffic
  // Mostly short gaps, a few long ones; none during a calm stretch
  function automatic int idle_length();
    int r;
    if (calm_left != 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Long receiver hold-off on request, plus random calm stretches
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
      calm_left  <= 0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
        hold_left  <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
      end
      if (calm_left != 0) begin
        calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 299) == 0) begin
        calm_left <= $urandom_range(50, 200);
      end
    end
  end

  // Byte driver: predicts on acceptance, then offers the next queued byte
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(rx_byte);
        accepted_count++;
        send_gap = idle_length();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string field, input int want_v,
                                      input int got_v);
    if (want_v != got_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
               want_v, got_v);
    end
  endfunction

  // Result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_points.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item: status %0d distance %0d angle %0d number %0d last %0d",
                   $time, status, distance, point_angle, point_number, last_point);
        end else begin
          due_point = predicted_points.pop_front();
          check_field("status", due_point.status, status);
          check_field("distance", due_point.distance, distance);
          check_field("point_angle", due_point.angle, point_angle);
          check_field("point_number", due_point.number, point_number);
          check_field("last_point", due_point.is_last, last_point);
        end
      end
      if (recv_gap > 0) recv_gap--;
      else recv_gap = idle_length();
      out_stall <= (hold_left != 0) || (recv_gap > 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    pushed_count++;
  endtask

  task automatic push_non_sync();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == SYNC_BYTE);
    push_byte(b);
  endtask

  function automatic logic [7:0] range_char(input bit noisy);
    if (noisy && $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return CHAR_BIAS + 8'($urandom_range(0, 63));
  endfunction

  // Sync byte, header, point characters with line feeds, trailing line feeds
  task automatic queue_scan(input int n_points, input bit noisy);
    int i;
    push_byte(SYNC_BYTE);
    for (i = 0; i < HEADER_BYTES; i++) push_byte(8'($urandom_range(0, 255)));
    for (i = 0; i < n_points; i++) begin
      if (i != 0 && i % POINTS_PER_LINE == 0)
        push_byte(noisy ? 8'($urandom_range(0, 255)) : LINE_FEED);
      // a zero high digit often lands near the range threshold
      push_byte(($urandom_range(0, 3) == 0) ? CHAR_BIAS : range_char(noisy));
      push_byte(range_char(noisy));
    end
    push_byte(LINE_FEED);
    push_byte(LINE_FEED);
  endtask

  task automatic wait_idle();
    while (accepted_count != pushed_count || predicted_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feed filler until the decoder is back to hunting
  task automatic finish_scan();
    wait_idle();
    while (scan_phase != SCAN_HUNT) begin
      repeat (16) push_byte(CHAR_BIAS);
      wait_idle();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIRST_STEP:   cfg_first     = data[STEP_W-1:0];
      REG_LAST_STEP:    cfg_last      = data[STEP_W-1:0];
      REG_GROUP_SIZE:   cfg_group     = data[GROUP_W-1:0];
      REG_ANGLE_ORIGIN: cfg_origin    = data[STEP_W-1:0];
      REG_MIN_RANGE:    cfg_min_range = data[DIST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int first_v, input int last_v, input int group_v,
                               input int origin_v, input int minr_v);
    write_reg(REG_FIRST_STEP, CFG_DATA_W'(first_v));
    write_reg(REG_LAST_STEP, CFG_DATA_W'(last_v));
    write_reg(REG_GROUP_SIZE, CFG_DATA_W'(group_v));
    write_reg(REG_ANGLE_ORIGIN, CFG_DATA_W'(origin_v & 'h3FF));
    write_reg(REG_MIN_RANGE, CFG_DATA_W'(minr_v));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    int r;
    int span;
    int first_v, last_v, group_v, origin_v, minr_v;
    int random_start;
    int phase_count;

    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults, receiver held off so the block backs up
    repeat (5) push_non_sync();
    queue_scan(scan_length(), 1'b0);
    hold_requests++;
    finish_scan();

    // Group size zero, angle wrap past -512, byte extremes, no threshold
    apply_setting(0, 5, 0, -512, 0);
    push_byte(SYNC_BYTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_BYTE);
    repeat (HEADER_BYTES - 3) push_byte(8'($urandom_range(0, 255)));
    push_byte(8'h30); push_byte(8'h30);
    push_byte(8'h6F); push_byte(8'h6F);
    push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'h2F); push_byte(8'h70);
    push_byte(SYNC_BYTE); push_byte(8'h80);
    push_byte(LINE_FEED);
    push_byte(8'h0D);
    finish_scan();

    // Last step below first: header only, hunting resumes
    apply_setting(1023, 0, 1, 511, 4095);
    queue_scan(0, 1'b0);
    finish_scan();

    // Last step equal to first
    apply_setting(100, 100, 2, 0, 100);
    queue_scan(0, 1'b0);
    finish_scan();

    // Line feed after a full line, top step, distances near threshold
    apply_setting(990, 1023, 1, -1, 64);
    queue_scan(scan_length(), 1'b0);
    finish_scan();

    // Sync timeout, then sync byte as the last byte before a timeout
    apply_setting(0, 3, 3, 0, 4095);
    n = SYNC_LIMIT - 1 - hunt_count;
    if (n < 0) n = 0;
    repeat (n) push_non_sync();
    push_non_sync();
    repeat (SYNC_LIMIT - 1) push_non_sync();
    push_byte(SYNC_BYTE);
    repeat (HEADER_BYTES) push_byte(8'($urandom_range(0, 255)));
    push_byte(8'h6F); push_byte(8'h6F);
    push_byte(SYNC_BYTE);
    repeat (HEADER_BYTES) push_byte(8'($urandom_range(0, 255)));
    push_byte(8'h6F); push_byte(8'h6E);
    finish_scan();

    // Random settings, each with a few frames, noise and cut-short frames
    random_start = pushed_count;
    phase_count  = 0;
    while (pushed_count - random_start < RANDOM_BYTES) begin
      first_v = $urandom_range(0, 1023);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        last_v = $urandom_range(0, first_v);
      end else begin
        span   = (r < 8) ? $urandom_range(1, 40) : $urandom_range(41, 200);
        last_v = (first_v + span > 1023) ? 1023 : first_v + span;
      end
      group_v = $urandom_range(0, 3);
      r = $urandom_range(0, 9);
      origin_v = (r < 2) ? -512 : (r < 4) ? 511 : int'($urandom_range(0, 1023)) - 512;
      r = $urandom_range(0, 9);
      minr_v = (r < 2) ? 0 : (r == 2) ? 4095 :
               (r < 7) ? $urandom_range(0, 100) : $urandom_range(0, 4095);
      apply_setting(first_v, last_v, group_v, origin_v, minr_v);

      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 3)) push_non_sync();
        r = $urandom_range(0, 19);
        if (r < 11) begin
          queue_scan(scan_length(), 1'b0);
        end else if (r < 14) begin
          queue_scan(scan_length(), 1'b1);
        end else if (r < 17) begin
          repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
        end else begin
          queue_scan($urandom_range(0, scan_length()), 1'b1);
        end
      end
      if (phase_count == 3) hold_requests++;
      finish_scan();
      phase_count++;
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
